>>> design/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the SMBIOS IPMI device record parser.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TABLE_LENGTH     = 2'd0,
        CFG_STRUCTURE_COUNT  = 2'd1,
        CFG_WANTED_INTERFACE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_MATCH     = 2'd0,
        ST_OTHER     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    localparam logic [1:0] ASP_MEMORY = 2'd0;
    localparam logic [1:0] ASP_IO     = 2'd1;
    localparam logic [1:0] ASP_SMBUS  = 2'd2;

    localparam logic [7:0] IPMI_RECORD_TYPE = 8'd38;
    localparam logic [7:0] MIN_RECORD_LEN   = 8'h10;
    localparam logic [7:0] LSB_RECORD_LEN   = 8'h12;
    localparam logic [7:0] SSIF_KIND        = 8'h04;
    localparam logic [7:0] HEADER_BYTES     = 8'h04;

    // Formatted-area offsets 4 through 0x10 are captured.
    localparam int FIRST_CAPTURED = 4;
    localparam int CAPTURE_DEPTH  = 13;
    localparam int CAPTURE_IDX_W  = 4;

    localparam logic [1:0] SPC_CODE_1  = 2'd0;
    localparam logic [1:0] SPC_CODE_4  = 2'd1;
    localparam logic [1:0] SPC_CODE_16 = 2'd2;
    localparam logic [1:0] SPC_CODE_KEEP = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        status_t     status;
        logic [7:0]  interface_kind;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
        logic [1:0]  address_space;
        logic [63:0] device_address;
        logic [4:0]  reg_stride;
        logic        last_of_run;
    } result_t;

    // Up to two results leave the parser for one table byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t not_found_result();
        result_t r;
        r = '0;
        r.status      = ST_NOT_FOUND;
        r.last_of_run = 1'b1;
        return r;
    endfunction

endpackage

>>> design/srp_fifo.sv
// ----------------------------------------------------------------------------
// srp_fifo
// Result queue: takes zero, one or two words per cycle, hands out one when not stalled.
// ----------------------------------------------------------------------------
module srp_fifo
    import srp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t head
);

    result_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign head         = mem[rd_ptr_reg];
    // Room for the largest burst from one byte.
    assign space_ok     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/srp_core.sv
// ----------------------------------------------------------------------------
// srp_core
// Input register and per-byte structure tracking; builds record results.
// ----------------------------------------------------------------------------
module srp_core
    import srp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] table_length,
    input  logic [15:0] structure_count,
    input  logic [7:0]  wanted_interface,
    input  logic        table_valid,
    output logic        table_stall,
    input  logic [7:0]  table_byte,
    input  logic        first_byte,
    input  logic        space_ok,
    output push_t       push
);

    // Input register.
    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        first_reg;
    logic        advance;

    // Parse state.
    logic [15:0] pos_reg,   pos_next;
    logic [16:0] start_reg, start_next;
    logic [15:0] seen_reg,  seen_next;
    logic [7:0]  hk_reg,    hk_next;
    logic [7:0]  hl_reg,    hl_next;
    logic        pz_reg,    pz_next;
    logic        fin_reg,   fin_next;
    logic [4:0]  held_reg,  held_next;
    logic [7:0]  rb_reg [CAPTURE_DEPTH];

    // Working signals.
    logic        restart;
    logic        empty_nf;
    logic [15:0] eff_pos;
    logic [16:0] eff_start;
    logic [15:0] eff_seen;
    logic [7:0]  eff_hk;
    logic [7:0]  eff_hl;
    logic        eff_pz;
    logic        eff_fin;
    logic [4:0]  eff_held;
    logic [15:0] off;
    logic [7:0]  hk_now;
    logic [7:0]  hl_now;
    logic        capture;
    logic [CAPTURE_IDX_W-1:0] cap_idx;
    logic        ended;
    logic        is_record;
    logic [15:0] seen_inc;
    logic [16:0] start_inc;
    logic        more;
    logic        table_done;
    logic [63:0] raw_addr;
    logic        lsb;
    logic [4:0]  rec_spacing;
    result_t     rec;
    result_t     nf;

    assign advance     = in_vld_reg && space_ok;
    assign table_stall = in_vld_reg && !space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!table_stall)
        begin
            in_vld_reg <= table_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_valid && !table_stall)
        begin
            byte_reg  <= table_byte;
            first_reg <= first_byte;
        end
    end

    // A start mark, or a fresh position after reset, begins a new table.
    always_comb
    begin
        restart   = first_reg || (!fin_reg && pos_reg == 16'd0);
        eff_pos   = restart ? 16'd0 : pos_reg;
        eff_start = restart ? 17'd0 : start_reg;
        eff_seen  = restart ? 16'd0 : seen_reg;
        eff_hk    = restart ? 8'd0  : hk_reg;
        eff_hl    = restart ? 8'd0  : hl_reg;
        eff_pz    = restart ? 1'b0  : pz_reg;
        eff_fin   = restart ? 1'b0  : fin_reg;
        eff_held  = restart ? 5'd0  : held_reg;
        empty_nf  = restart && (structure_count == 16'd0
                                || table_length < {8'd0, HEADER_BYTES});
    end

    always_comb
    begin
        off     = eff_pos - eff_start[15:0];
        hk_now  = (off == 16'd0) ? byte_reg : eff_hk;
        hl_now  = (off == 16'd1) ? byte_reg : eff_hl;
        capture = (off >= 16'(FIRST_CAPTURED))
                  && (off < 16'(FIRST_CAPTURED + CAPTURE_DEPTH));
        cap_idx = CAPTURE_IDX_W'(off - 16'(FIRST_CAPTURED));
        // The zero pair must begin at or after start plus length.
        ended   = ({1'b0, off} >= ({9'd0, hl_now} + 17'd1)) && eff_pz
                  && (byte_reg == 8'd0) && (eff_pos < table_length);
        is_record  = ended && (hk_now == IPMI_RECORD_TYPE) && (hl_now >= MIN_RECORD_LEN);
        seen_inc   = eff_seen + 16'd1;
        start_inc  = {1'b0, eff_pos} + 17'd1;
        more       = (seen_inc < structure_count)
                     && (({1'b0, start_inc} + 18'd4) <= {2'd0, table_length});
        table_done = ({1'b0, eff_pos} + 17'd1) >= {1'b0, table_length};
    end

    // Record decode; the ending byte lies past offset 0x10, so the
    // captured bytes are complete without it.
    always_comb
    begin
        raw_addr = {rb_reg[11], rb_reg[10], rb_reg[9], rb_reg[8],
                    rb_reg[7], rb_reg[6], rb_reg[5], rb_reg[4]};
        lsb      = (hl_now >= LSB_RECORD_LEN) ? rb_reg[12][5] : 1'b0;
        unique case (rb_reg[12][7:6])
            SPC_CODE_1:    rec_spacing = 5'd1;
            SPC_CODE_4:    rec_spacing = 5'd4;
            SPC_CODE_16:   rec_spacing = 5'd16;
            SPC_CODE_KEEP: rec_spacing = eff_held;
            default:       rec_spacing = eff_held;
        endcase
        rec = '0;
        rec.status         = (rb_reg[0] == wanted_interface) ? ST_MATCH : ST_OTHER;
        rec.interface_kind = rb_reg[0];
        rec.version_major  = rb_reg[1][7:4];
        rec.version_minor  = rb_reg[1][3:0];
        rec.last_of_run    = 1'b1;
        if (rb_reg[0] == SSIF_KIND)
        begin
            rec.address_space  = ASP_SMBUS;
            rec.device_address = {57'd0, rb_reg[2][7:1]};
            rec.reg_stride     = 5'd1;
        end
        else
        begin
            rec.address_space  = raw_addr[0] ? ASP_IO : ASP_MEMORY;
            rec.device_address = {raw_addr[63:1], lsb};
            rec.reg_stride     = rec_spacing;
        end
        nf = not_found_result();
    end

    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        hk_next    = hk_reg;
        hl_next    = hl_reg;
        pz_next    = pz_reg;
        fin_next   = fin_reg;
        held_next  = held_reg;
        push       = '0;
        if (advance)
        begin
            pos_next   = eff_pos;
            start_next = eff_start;
            seen_next  = eff_seen;
            hk_next    = eff_hk;
            hl_next    = eff_hl;
            pz_next    = eff_pz;
            fin_next   = eff_fin;
            held_next  = eff_held;
            if (empty_nf)
            begin
                push.count = 2'd1;
                push.first = nf;
                fin_next   = 1'b1;
            end
            else if (!eff_fin)
            begin
                hk_next  = hk_now;
                hl_next  = hl_now;
                pz_next  = (byte_reg == 8'd0);
                pos_next = eff_pos + 16'd1;
                if (ended)
                begin
                    if (is_record)
                    begin
                        held_next  = rec.reg_stride;
                        push.count = 2'd1;
                        push.first = rec;
                    end
                    if (is_record && rec.status == ST_MATCH)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        seen_next  = seen_inc;
                        start_next = start_inc;
                        hk_next    = 8'd0;
                        hl_next    = 8'd0;
                        pz_next    = 1'b0;
                        if (!more)
                        begin
                            fin_next = 1'b1;
                            if (is_record)
                            begin
                                // Record and not-found leave together.
                                push.count             = 2'd2;
                                push.first.last_of_run = 1'b0;
                                push.second            = nf;
                            end
                            else
                            begin
                                push.count = 2'd1;
                                push.first = nf;
                            end
                        end
                    end
                end
                else if (table_done)
                begin
                    push.count = 2'd1;
                    push.first = nf;
                    fin_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !empty_nf && !eff_fin && capture)
        begin
            rb_reg[cap_idx] <= byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            seen_reg  <= '0;
            hk_reg    <= '0;
            hl_reg    <= '0;
            pz_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            seen_reg  <= seen_next;
            hk_reg    <= hk_next;
            hl_reg    <= hl_next;
            pz_reg    <= pz_next;
            fin_reg   <= fin_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> design/smbios_ipmi_record_parser.sv
// ----------------------------------------------------------------------------
// smbios_ipmi_record_parser
// Scans an SMBIOS structure table byte by byte and reports IPMI device
// records (type 38) and the end of the search.
// ----------------------------------------------------------------------------
// Each accepted table byte is registered, then its results enter the queue.
// Throughput: one table byte per cycle unless table_stall is high; a byte that
// ends the search after a non-matching record gives two results, which the
// four-word queue absorbs; the output gives one word per unstalled cycle.
// Reset clears the configuration registers, the parse state and the queue;
// the first byte after reset starts a table even without its start mark.
// ----------------------------------------------------------------------------
module smbios_ipmi_record_parser
    import srp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       table_valid,
    output logic                       table_stall,
    input  logic [7:0]                 table_byte,
    input  logic                       first_byte,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [1:0]                 status,
    output logic [7:0]                 interface_kind,
    output logic [3:0]                 version_major,
    output logic [3:0]                 version_minor,
    output logic [1:0]                 address_space,
    output logic [63:0]                device_address,
    output logic [4:0]                 reg_stride,
    output logic                       last_of_run
);

    logic [15:0] table_length_reg;
    logic [15:0] structure_count_reg;
    logic [7:0]  wanted_interface_reg;
    logic        space_ok;
    push_t       push;
    result_t     head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg     <= '0;
            structure_count_reg  <= '0;
            wanted_interface_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TABLE_LENGTH:     table_length_reg     <= cfg_data;
                CFG_STRUCTURE_COUNT:  structure_count_reg  <= cfg_data;
                CFG_WANTED_INTERFACE: wanted_interface_reg <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    srp_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .table_length     (table_length_reg),
        .structure_count  (structure_count_reg),
        .wanted_interface (wanted_interface_reg),
        .table_valid      (table_valid),
        .table_stall      (table_stall),
        .table_byte       (table_byte),
        .first_byte       (first_byte),
        .space_ok         (space_ok),
        .push             (push)
    );

    srp_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign status         = head.status;
    assign interface_kind = head.interface_kind;
    assign version_major  = head.version_major;
    assign version_minor  = head.version_minor;
    assign address_space  = head.address_space;
    assign device_address = head.device_address;
    assign reg_stride     = head.reg_stride;
    assign last_of_run    = head.last_of_run;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams SMBIOS structure tables into the IPMI record parser and checks every
// result word against a cycle-free model of the parse kept in a scoreboard.
// Tables are mostly well-formed structures with random contents, mixed with
// junk bytes, restarts, truncated lengths and structure limits.
// ----------------------------------------------------------------------------
module testbench
    import srp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    // A well-formed SSIF record of minimum length that ends right at the table end.
    localparam logic [7:0] SSIF_SAMPLE [18] = '{
        8'd38, 8'h10, 8'hFF, 8'hFF, 8'h04, 8'hA5, 8'hFF, 8'h00, 8'hFF,
        8'h00, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'hC3, 8'h00, 8'h00
    };

    class record_scoreboard;
        logic [15:0] tbl_len;
        logic [15:0] struct_limit;
        logic [7:0]  wanted_kind;
        int unsigned pos;
        int unsigned start;
        int unsigned seen;
        logic [7:0]  hdr_kind;
        logic [7:0]  hdr_len;
        logic [7:0]  rec [CAPTURE_DEPTH];
        bit          prev_zero;
        bit          done;
        logic [4:0]  spacing;
        result_t     pending_records[$];
        int          mismatches;

        function new();
            tbl_len      = '0;
            struct_limit = '0;
            wanted_kind  = '0;
            mismatches   = 0;
            clear_parse();
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_TABLE_LENGTH:     tbl_len = value;
                CFG_STRUCTURE_COUNT:  struct_limit = value;
                CFG_WANTED_INTERFACE: wanted_kind = value[7:0];
                default: ;
            endcase
        endfunction

        function void clear_parse();
            pos       = 0;
            start     = 0;
            seen      = 0;
            hdr_kind  = '0;
            hdr_len   = '0;
            foreach (rec[i]) rec[i] = '0;
            prev_zero = 1'b0;
            done      = 1'b0;
            spacing   = '0;
        endfunction

        function bit more_structures();
            return seen < struct_limit && start + 4 <= tbl_len;
        endfunction

        function void queue_result(result_t r);
            pending_records.push_back(r);
        endfunction

        function void queue_not_found();
            result_t r;
            r             = '0;
            r.status      = ST_NOT_FOUND;
            r.last_of_run = 1'b1;
            queue_result(r);
            done = 1'b1;
        endfunction

        function result_t decode_record();
            result_t     r;
            logic [63:0] raw;
            r = '0;
            r.interface_kind = rec[0];
            r.version_major  = rec[1][7:4];
            r.version_minor  = rec[1][3:0];
            if (rec[0] == SSIF_KIND) begin
                r.address_space  = ASP_SMBUS;
                r.device_address = {57'd0, rec[2][7:1]};
                spacing = 5'd1;
            end
            else begin
                raw = {rec[11], rec[10], rec[9], rec[8], rec[7], rec[6], rec[5], rec[4]};
                r.device_address = {raw[63:1],
                                    (hdr_len >= LSB_RECORD_LEN) ? rec[12][5] : 1'b0};
                r.address_space  = raw[0] ? ASP_IO : ASP_MEMORY;
                case (rec[12][7:6])
                    SPC_CODE_1:  spacing = 5'd1;
                    SPC_CODE_4:  spacing = 5'd4;
                    SPC_CODE_16: spacing = 5'd16;
                    default: ;
                endcase
            end
            r.status      = (rec[0] == wanted_kind) ? ST_MATCH : ST_OTHER;
            r.reg_stride  = spacing;
            r.last_of_run = 1'b1;
            return r;
        endfunction

        // Returns 1 unless the byte is ignored after the search has ended.
        function bit take_byte(logic [7:0] value, logic restart_mark);
            int unsigned q;
            int unsigned off;
            bit          ended;
            bit          have_record;
            result_t     r;
            if (restart_mark || (!done && pos == 0)) begin
                clear_parse();
                if (!more_structures()) begin
                    queue_not_found();
                    return 1'b1;
                end
            end
            if (done)
                return 1'b0;

            q   = pos;
            off = q - start;
            if (off == 0)
                hdr_kind = value;
            else if (off == 1)
                hdr_len = value;
            if (off >= FIRST_CAPTURED && off < FIRST_CAPTURED + CAPTURE_DEPTH)
                rec[off - FIRST_CAPTURED] = value;

            ended = off >= hdr_len + 1 && prev_zero && value == 8'h00 && q < tbl_len;
            prev_zero = (value == 8'h00);
            pos = (q + 1) & 32'hFFFF;

            if (ended) begin
                have_record = hdr_kind == IPMI_RECORD_TYPE && hdr_len >= MIN_RECORD_LEN;
                if (have_record) begin
                    r = decode_record();
                    if (r.status == ST_MATCH) begin
                        queue_result(r);
                        done = 1'b1;
                        return 1'b1;
                    end
                end
                seen      = (seen + 1) & 32'hFFFF;
                start     = q + 1;
                hdr_kind  = '0;
                hdr_len   = '0;
                prev_zero = 1'b0;
                // A record that also exhausts the table is followed by the not-found word.
                if (have_record) begin
                    if (!more_structures())
                        r.last_of_run = 1'b0;
                    queue_result(r);
                end
                if (!more_structures())
                    queue_not_found();
                return 1'b1;
            end
            if (q + 1 >= tbl_len)
                queue_not_found();
            return 1'b1;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                report($sformatf("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_records.size() == 0) begin
                report($sformatf("result word with nothing pending, status %0d",
                                 got.status));
                return;
            end
            want = pending_records.pop_front();
            check_field("status", want.status, got.status);
            check_field("interface_kind", want.interface_kind, got.interface_kind);
            check_field("version_major", want.version_major, got.version_major);
            check_field("version_minor", want.version_minor, got.version_minor);
            check_field("address_space", want.address_space, got.address_space);
            check_field("device_address", want.device_address, got.device_address);
            check_field("reg_stride", want.reg_stride, got.reg_stride);
            check_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    cfg_index_t                cfg_index = CFG_TABLE_LENGTH;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic                      table_valid = 1'b0;
    logic                      table_stall;
    logic [7:0]                table_byte = '0;
    logic                      first_byte = 1'b0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic [1:0]                status;
    logic [7:0]                interface_kind;
    logic [3:0]                version_major;
    logic [3:0]                version_minor;
    logic [1:0]                address_space;
    logic [63:0]               device_address;
    logic [4:0]                reg_stride;
    logic                      last_of_run;

    record_scoreboard sb;
    logic [7:0]       table_image[$];
    int               consumed = 0;
    int               idle_cycles = 0;
    bit               calm = 1'b0;

    smbios_ipmi_record_parser DUT (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < 27);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result({status, interface_kind, version_major, version_minor,
                             address_space, device_address, reg_stride, last_of_run});

    always @(posedge clk) begin
        if (!rst_n || (table_valid && !table_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] value, logic restart_mark);
        calm = (consumed >= 300 && consumed < 450);
        while (!calm && $urandom_range(0, 99) < 27) begin
            table_valid <= 1'b0;
            @(posedge clk);
        end
        table_valid <= 1'b1;
        table_byte  <= value;
        first_byte  <= restart_mark;
        @(posedge clk);
        while (table_stall)
            @(posedge clk);
        void'(sb.take_byte(value, restart_mark));
        consumed++;
    endtask

    // Waits until every pending word has come out, then lets the pipeline empty.
    task automatic settle();
        table_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_records.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] tl, logic [15:0] cnt, logic [7:0] want);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TABLE_LENGTH;
        cfg_data  <= tl;
        @(posedge clk);
        cfg_index <= CFG_STRUCTURE_COUNT;
        cfg_data  <= cnt;
        @(posedge clk);
        cfg_index <= CFG_WANTED_INTERFACE;
        cfg_data  <= {8'h00, want};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(CFG_TABLE_LENGTH, tl);
        sb.set_reg(CFG_STRUCTURE_COUNT, cnt);
        sb.set_reg(CFG_WANTED_INTERFACE, {8'h00, want});
    endtask

    // Appends one structure: header, formatted area, then a string set.
    function automatic void add_structure(bit ipmi);
        logic [7:0] kind;
        logic [7:0] len;
        int         body;
        int         n_strings;
        int         i;
        int         j;
        if (ipmi || $urandom_range(0, 9) == 0)
            kind = IPMI_RECORD_TYPE;
        else
            kind = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: len = 8'($urandom_range(0, 3));
            1: len = 8'($urandom_range(4, 15));
            2: len = 8'($urandom_range(19, 40));
            default: len = 8'($urandom_range(16, 18));
        endcase
        table_image.push_back(kind);
        table_image.push_back(len);
        table_image.push_back(8'($urandom));
        table_image.push_back(8'($urandom));
        body = (len > 4) ? len - 4 : 0;
        for (i = 0; i < body; i++) begin
            if (i == 0 && $urandom_range(0, 5) != 5)
                table_image.push_back(8'($urandom_range(0, 4)));
            else
                table_image.push_back(8'($urandom));
        end
        n_strings = $urandom_range(0, 2);
        for (i = 0; i < n_strings; i++) begin
            for (j = $urandom_range(1, 4); j > 0; j--)
                table_image.push_back(8'($urandom_range(1, 255)));
            table_image.push_back(8'h00);
        end
        if (n_strings == 0)
            table_image.push_back(8'h00);
        table_image.push_back(8'h00);
    endfunction

    initial begin
        int          i;
        int          j;
        int          n;
        int          size;
        int          cut;
        logic [15:0] tl;
        logic [15:0] cnt;
        logic [7:0]  want;
        logic        mark;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the first word starts a table even without its start mark;
        // with a structure limit of zero the search ends at once.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // A table too short for even one header.
        settle();
        configure(16'd3, 16'hFFFF, 8'h00);
        send_byte(8'h80, 1'b1);

        // One SSIF record that matches.
        settle();
        configure(16'd18, 16'd1, SSIF_KIND);
        for (i = 0; i < 18; i++)
            send_byte(SSIF_SAMPLE[i], i == 0);

        while (consumed < 750) begin
            table_image.delete();
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0)
                    for (j = $urandom_range(1, 6); j > 0; j--)
                        table_image.push_back(8'($urandom));
                add_structure($urandom_range(0, 9) < 6);
            end
            size = table_image.size();

            case ($urandom_range(0, 9))
                6: tl = 16'($urandom_range(0, size - 1));
                7: tl = 16'hFFFF;
                8: tl = 16'(size + $urandom_range(1, 8));
                9: tl = 16'($urandom_range(0, 3));
                default: tl = 16'(size);
            endcase
            case ($urandom_range(0, 9))
                6, 7: cnt = 16'($urandom_range(1, n));
                8: cnt = 16'h0000;
                9: cnt = 16'($urandom);
                default: cnt = 16'hFFFF;
            endcase
            case ($urandom_range(0, 9))
                7: want = 8'h00;
                8: want = 8'hFF;
                9: want = 8'($urandom);
                default: want = 8'($urandom_range(0, 4));
            endcase

            settle();
            configure(tl, cnt, want);
            // Now and then the table length is set anew, to at most cut plus four, while a table is in flight.
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, size - 1) : -1;
            for (i = 0; i < size; i++) begin
                if (i == cut) begin
                    settle();
                    configure(16'($urandom_range(0, cut + 4)), cnt, want);
                end
                if (i == 0)
                    mark = ($urandom_range(0, 9) != 0);
                else
                    mark = ($urandom_range(0, 199) == 0);
                send_byte(table_image[i], mark);
            end
        end

        settle();
        repeat (4) @(posedge clk);
        while (sb.pending_records.size() != 0) begin
            sb.report($sformatf("expected word never arrived, status %0d",
                                sb.pending_records[0].status));
            void'(sb.pending_records.pop_front());
        end
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
